// File: hdl/tske_pkg.sv
// ----------------------------------------------------------------------------
// tske_pkg
// Shared types and constants for the touch swipe to key event block.
// ----------------------------------------------------------------------------
`default_nettype none

package tske_pkg;

  typedef enum logic {
    MODE_TICK   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    KIND_REPORT  = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    REG_COOLDOWN  = 3'd0,
    REG_REL_DELAY = 3'd1,
    REG_MAJOR     = 3'd2,
    REG_MINOR     = 3'd3,
    REG_REPORT_EN = 3'd4
  } reg_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ClockW    = 32;
  localparam int unsigned CooldownW = 16;
  localparam int unsigned DelayW    = 8;
  localparam int unsigned ThrW      = 7;
  localparam int unsigned DeltaW    = 8;

  localparam logic [CooldownW-1:0] CooldownRst = 16'd100;
  localparam logic [DelayW-1:0]    DelayRst    = 8'd10;
  localparam logic [ThrW-1:0]      MajorRst    = 7'd15;
  localparam logic [ThrW-1:0]      MinorRst    = 7'd5;

  typedef struct packed {
    logic [ThrW-1:0] major;
    logic [ThrW-1:0] minor;
  } thr_t;

  typedef struct packed {
    logic hit;
    dir_e dir;
  } swipe_t;

endpackage

`default_nettype wire

// File: hdl/tske_swipe.sv
// ----------------------------------------------------------------------------
// tske_swipe
// Dominant-axis swipe classifier: checks the vertical axis first, then the
// horizontal one, against the major and minor thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module tske_swipe (
  input  logic [tske_pkg::DeltaW-1:0] x_i,
  input  logic [tske_pkg::DeltaW-1:0] y_i,
  input  tske_pkg::thr_t              thr_i,
  output tske_pkg::swipe_t            swipe_o
);

  logic [tske_pkg::DeltaW-1:0] ax;
  logic [tske_pkg::DeltaW-1:0] ay;
  logic [tske_pkg::DeltaW-1:0] major;
  logic [tske_pkg::DeltaW-1:0] minor;
  logic                        vert;
  logic                        horz;

  // magnitude as unsigned, so -128 reads as 128
  assign ax    = x_i[tske_pkg::DeltaW-1] ? (~x_i + 1'b1) : x_i;
  assign ay    = y_i[tske_pkg::DeltaW-1] ? (~y_i + 1'b1) : y_i;
  assign major = {1'b0, thr_i.major};
  assign minor = {1'b0, thr_i.minor};
  assign vert  = (ay >= major) && (ax <= minor);
  assign horz  = (ax >= major) && (ay <= minor);

  always_comb begin
    swipe_o.hit = vert || horz;
    swipe_o.dir = tske_pkg::DIR_UP;
    priority if (vert) begin
      swipe_o.dir = y_i[tske_pkg::DeltaW-1] ? tske_pkg::DIR_UP : tske_pkg::DIR_DOWN;
    end else if (horz) begin
      swipe_o.dir = x_i[tske_pkg::DeltaW-1] ? tske_pkg::DIR_LEFT : tske_pkg::DIR_RIGHT;
    end else begin
      swipe_o.dir = tske_pkg::DIR_UP;
    end
  end

endmodule

`default_nettype wire

// File: hdl/touch_swipe_to_key_events_top.sv
// Path: a beat is accepted into the input register; its result then goes
//   into the result register, which drives the master side.
// Throughput: one beat per cycle, but a beat that makes a result waits in the
//   input register while an earlier result is still waiting to be taken.
// Reset: rst_ni clears the clocks, the pending release and both registers,
//   and loads the configuration defaults.
// ----------------------------------------------------------------------------
// touch_swipe_to_key_events_top
// Turns millisecond ticks and touch motion samples into motion reports and
// swipe key press and release events.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_swipe_to_key_events_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [tske_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tske_pkg::CfgDataW-1:0]     cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // motion_flag, raw_dx, raw_dy, alt_held
  input  logic                              s_axis_tuser,  // mode
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // direction, report_x, report_y
  output logic [1:0]                        m_axis_tuser   // event_kind
);

  localparam int unsigned DW = tske_pkg::DeltaW;

  // configuration
  logic [tske_pkg::CooldownW-1:0] cooldown_q;
  logic [tske_pkg::DelayW-1:0]    delay_q;
  tske_pkg::thr_t                 thr_q;
  logic                           report_en_q;

  // input register
  logic                           s1_valid_q;
  tske_pkg::mode_e                s1_mode_q;
  logic                           s1_motion_q;
  logic [DW-1:0]                  s1_dx_q;
  logic [DW-1:0]                  s1_dy_q;
  logic                           s1_alt_q;

  // block state
  logic [tske_pkg::ClockW-1:0]    ms_q, ms_d;
  logic [tske_pkg::ClockW-1:0]    last_q, last_d;
  logic                           pend_q, pend_d;
  logic [tske_pkg::DelayW-1:0]    cnt_q, cnt_d;
  tske_pkg::dir_e                 pdir_q, pdir_d;

  // result register
  logic                           out_valid_q;
  tske_pkg::kind_e                out_kind_q;
  tske_pkg::dir_e                 out_dir_q;
  logic [DW-1:0]                  out_x_q;
  logic [DW-1:0]                  out_y_q;

  logic                           res_valid;
  tske_pkg::kind_e                res_kind;
  tske_pkg::dir_e                 res_dir;
  logic [DW-1:0]                  res_x;
  logic [DW-1:0]                  res_y;

  logic [DW-1:0]                  x_neg;
  logic [tske_pkg::ClockW-1:0]    elapsed;
  logic                           cool_ok;
  tske_pkg::swipe_t               swipe;
  logic                           out_free;
  logic                           s1_fire;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q  <= tske_pkg::CooldownRst;
      delay_q     <= tske_pkg::DelayRst;
      thr_q.major <= tske_pkg::MajorRst;
      thr_q.minor <= tske_pkg::MinorRst;
      report_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (tske_pkg::reg_e'(cfg_idx_i))
        tske_pkg::REG_COOLDOWN:  cooldown_q  <= cfg_data_i;
        tske_pkg::REG_REL_DELAY: delay_q     <= cfg_data_i[tske_pkg::DelayW-1:0];
        tske_pkg::REG_MAJOR:     thr_q.major <= cfg_data_i[tske_pkg::ThrW-1:0];
        tske_pkg::REG_MINOR:     thr_q.minor <= cfg_data_i[tske_pkg::ThrW-1:0];
        tske_pkg::REG_REPORT_EN: report_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ handshakes
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && (!res_valid || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_mode_q   <= tske_pkg::mode_e'(s_axis_tuser);
      s1_motion_q <= s_axis_tdata[0];
      s1_dx_q     <= s_axis_tdata[DW:1];
      s1_dy_q     <= s_axis_tdata[2*DW:DW+1];
      s1_alt_q    <= s_axis_tdata[2*DW+1];
    end
  end

  // --------------------------------------------------------------- decide
  assign x_neg   = ~s1_dx_q + 1'b1;
  assign elapsed = ms_q - last_q;
  assign cool_ok = elapsed > {{(tske_pkg::ClockW-tske_pkg::CooldownW){1'b0}}, cooldown_q};

  tske_swipe u_swipe (
    .x_i     (x_neg),
    .y_i     (s1_dy_q),
    .thr_i   (thr_q),
    .swipe_o (swipe)
  );

  always_comb begin
    ms_d      = ms_q;
    last_d    = last_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    pdir_d    = pdir_q;
    res_valid = 1'b0;
    res_kind  = tske_pkg::KIND_REPORT;
    res_dir   = tske_pkg::DIR_UP;
    res_x     = '0;
    res_y     = '0;
    if (s1_mode_q == tske_pkg::MODE_TICK) begin
      ms_d = ms_q + 1'b1;
      if (pend_q) begin
        // a zero delay ends on the next tick, like a delay of one
        if (cnt_q <= 8'd1) begin
          cnt_d     = '0;
          pend_d    = 1'b0;
          res_valid = 1'b1;
          res_kind  = tske_pkg::KIND_RELEASE;
          res_dir   = pdir_q;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end else if (s1_motion_q) begin
      if (!s1_alt_q) begin
        if (report_en_q) begin
          res_valid = 1'b1;
          res_x     = x_neg;
          res_y     = s1_dy_q;
        end
      end else if (cool_ok && swipe.hit && !pend_q) begin
        pend_d    = 1'b1;
        cnt_d     = delay_q;
        pdir_d    = swipe.dir;
        last_d    = ms_q;
        res_valid = 1'b1;
        res_kind  = tske_pkg::KIND_PRESS;
        res_dir   = swipe.dir;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q   <= '0;
      last_q <= '0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
      pdir_q <= tske_pkg::DIR_UP;
    end else if (s1_fire) begin
      ms_q   <= ms_d;
      last_q <= last_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      pdir_q <= pdir_d;
    end
  end

  // --------------------------------------------------------------- result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_kind_q <= res_kind;
      out_dir_q  <= res_dir;
      out_x_q    <= res_x;
      out_y_q    <= res_y;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {6'b0, out_y_q, out_x_q, out_dir_q};

endmodule

`default_nettype wire

// File: hdl/tske_chk.sv
// ----------------------------------------------------------------------------
// tske_chk
// Port-level checks for the touch swipe to key event block.
// ----------------------------------------------------------------------------
`default_nettype none

module tske_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [23:0]                   m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // key events carry no motion
  a_press_no_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tske_pkg::KIND_PRESS) |->
      (m_axis_tdata[17:2] == 16'd0))
    else $error("key press with motion data");

  a_release_no_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tske_pkg::KIND_RELEASE) |->
      (m_axis_tdata[17:2] == 16'd0))
    else $error("key release with motion data");

  // motion reports carry no direction
  a_report_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tske_pkg::KIND_REPORT) |->
      (m_axis_tdata[1:0] == tske_pkg::DIR_UP))
    else $error("motion report with direction");

endmodule

bind touch_swipe_to_key_events_top tske_chk u_tske_chk (.*);

`default_nettype wire
